>>> hw/rtl/windowed_claim_hit_matcher_top_defines.svh
// Assertion macros shared by the matcher RTL.
// Depends on nothing; included by the controller and datapath files.
`ifndef WINDOWED_CLAIM_HIT_MATCHER_TOP_DEFINES_SVH
`define WINDOWED_CLAIM_HIT_MATCHER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define WCHM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define WCHM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/wchm_pkg.sv
// Shared types, codes and sizes of the windowed claim/hit matcher.
// No dependencies; imported by the controller, datapath and top level.
package wchm_pkg;

	localparam int unsigned CLAIM_DEPTH = 128;
	localparam int unsigned HIT_DEPTH   = 64;
	localparam int unsigned CLAIM_AW    = $clog2(CLAIM_DEPTH);
	localparam int unsigned HIT_AW      = $clog2(HIT_DEPTH);
	localparam int unsigned SCAN_W      = (CLAIM_AW > HIT_AW) ? CLAIM_AW : HIT_AW;

	localparam int unsigned PID_W  = 22;
	localparam int unsigned OP_W   = 32;
	localparam int unsigned PATH_W = 64;
	localparam int unsigned TS_W   = 32;
	localparam int unsigned WIN_W  = 8;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned OUTC_W = 3;

	localparam int unsigned CFG_IDX_W = 4;

	localparam logic [WIN_W-1:0] CLAIM_WIN_RESET = WIN_W'(5);
	localparam logic [WIN_W-1:0] DEDUP_WIN_RESET = WIN_W'(15);

	// One ring entry; bit order matches the input transaction layout
	typedef struct packed {
		logic [TS_W-1:0]   stamp;
		logic [PATH_W-1:0] path;
		logic [OP_W-1:0]   op;
		logic [PID_W-1:0]  pid;
	} entry_t;

	localparam int unsigned ENTRY_W    = $bits(entry_t);
	localparam int unsigned IN_DATA_W  = ((ENTRY_W + 7) / 8) * 8;
	localparam int unsigned OUT_DATA_W = 8;

	typedef enum logic [KIND_W-1:0] {
		KIND_CLAIM     = 2'd0,
		KIND_OBSERVE   = 2'd1,
		KIND_CLEAR     = 2'd2,
		KIND_CLEAR_ALT = 2'd3
	} kind_t;

	typedef enum logic [OUTC_W-1:0] {
		OUT_CLAIM_STORED = 3'd0,
		OUT_EMPTY_PATH   = 3'd1,
		OUT_CLAIMED      = 3'd2,
		OUT_DUPLICATE    = 3'd3,
		OUT_NEW_HIT      = 3'd4,
		OUT_CLEARED      = 3'd5
	} outcome_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CLAIM_WIN = 4'd0,
		CFG_DEDUP_WIN = 4'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CSCAN,
		ST_HSCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic scan_claim;
		logic scan_hit;
		logic idx_clr;
		logic finish;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic needs_scan;
		logic last_claim;
		logic last_hit;
		logic out_free;
	} dp_sts_t;

endpackage

>>> hw/rtl/windowed_claim_hit_matcher_top.sv
// Channel   Signals                              Payload
// s_axis    s_axis_tvalid/tready/tdata/tuser     tuser kind, tdata item fields
// m_axis    m_axis_tvalid/tready/tdata           new_hit, outcome
// cfg       cfg_valid/cfg_ready/cfg_index/data   window register writes
//
// A claim, a clear or an empty-path observe holds the block from acceptance to
// the finish step, which loads its result. An observe with a non-empty path holds
// it through a claim ring scan, a hit ring scan, a drain step and finish; the scans
// use the single read port of each ring RAM, one entry per cycle.
// arst_n clears valid bits and pointers and resets windows at once; no clearing pass.
// A new transaction is taken while an earlier result waits; a held result
// stalls only the finish step.
// Top level of the windowed claim/hit matcher; depends on wchm_pkg,
// wchm_ctrl and wchm_dp.
module windowed_claim_hit_matcher_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [21:0] process_id, [53:22] op_tag, [117:54] path_tag,
	// [149:118] now_seconds, [151:150] zero
	input  logic [wchm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// [1:0] kind
	input  logic [wchm_pkg::KIND_W-1:0]        s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [0] new_hit, [3:1] outcome, [7:4] zero
	output logic [wchm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [wchm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wchm_pkg::WIN_W-1:0]         cfg_data
);
	import wchm_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Register writes are always taken
	assign cfg_ready = 1'b1;

	wchm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	wchm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_axis_tdata),
		.s_tuser   (s_axis_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_axis_tvalid),
		.m_tready  (m_axis_tready),
		.m_tdata   (m_axis_tdata)
	);

endmodule

>>> hw/rtl/wchm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for both entry rings.
module wchm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/wchm_ctrl.sv
// Sequencer of the matcher: accept, claim scan, hit scan, drain, finish.
// Depends on wchm_pkg and the assertion macro header.
`include "windowed_claim_hit_matcher_top_defines.svh"

module wchm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_valid,
	output logic              s_ready,
	input  wchm_pkg::dp_sts_t sts,
	output wchm_pkg::dp_cmd_t cmd
);
	import wchm_pkg::*;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		s_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_ready = 1'b1;
				if (s_valid) begin
					cmd.accept = 1'b1;
					state_d    = sts.needs_scan ? ST_CSCAN : ST_FINISH;
				end
			end
			ST_CSCAN: begin
				cmd.scan_claim = 1'b1;
				if (sts.last_claim) begin
					cmd.idx_clr = 1'b1;
					state_d     = ST_HSCAN;
				end
			end
			ST_HSCAN: begin
				cmd.scan_hit = 1'b1;
				if (sts.last_hit) begin
					state_d = ST_DRAIN;
				end
			end
			// last hit entry is compared here
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`WCHM_ASSERT_NEXT(a_claim_scan_ends, clk, arst_n, (state_q == ST_CSCAN) && sts.last_claim, state_q == ST_HSCAN, "claim scan did not hand over to hit scan")
	`WCHM_ASSERT_NEXT(a_finish_to_idle, clk, arst_n, cmd.finish, (state_q == ST_IDLE) && !cmd.scan_claim, "finish did not return to idle")

endmodule

>>> hw/rtl/wchm_dp.sv
// Datapath: item latch, both rings with their valid bits and pointers,
// scan compare, windows and the result register. Depends on wchm_pkg, wchm_ram.
`include "windowed_claim_hit_matcher_top_defines.svh"

module wchm_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [wchm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wchm_pkg::WIN_W-1:0]          cfg_data,
	input  logic [wchm_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic [wchm_pkg::KIND_W-1:0]         s_tuser,
	input  wchm_pkg::dp_cmd_t                   cmd,
	output wchm_pkg::dp_sts_t                   sts,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [wchm_pkg::OUT_DATA_W-1:0]     m_tdata
);
	import wchm_pkg::*;

	logic [WIN_W-1:0]    claim_win_q, dedup_win_q;
	entry_t              item_q;
	kind_t               kind_q;
	entry_t              in_item;
	logic [SCAN_W-1:0]   idx_q;
	logic [CLAIM_AW-1:0] claim_ptr_q;
	logic [HIT_AW-1:0]   hit_ptr_q;
	logic [CLAIM_DEPTH-1:0] claim_valid_q;
	logic [HIT_DEPTH-1:0]   hit_valid_q;
	logic                rd_claim_s1, rd_hit_s1;
	logic                vld_claim_s1, vld_hit_s1;
	entry_t              claim_rd, hit_rd;
	logic                claim_match, hit_match;
	logic                claimed_q, dup_q;
	outcome_t            outcome;
	logic                out_valid_q;
	outcome_t            out_outcome_q;
	logic                claim_we, hit_we, clear_all;

	function automatic logic entry_hits(entry_t e, entry_t k, logic [WIN_W-1:0] win);
		logic key_eq;
		logic pid_ok;
		logic [TS_W-1:0] age;
		key_eq = (e.op == k.op) && (e.path == k.path);
		pid_ok = (k.pid == '0) || (e.pid == '0) || (k.pid == e.pid);
		age    = k.stamp - e.stamp;
		return key_eq && pid_ok && (age <= TS_W'(win));
	endfunction

	assign in_item = entry_t'(s_tdata[ENTRY_W-1:0]);

	// Configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			claim_win_q <= CLAIM_WIN_RESET;
			dedup_win_q <= DEDUP_WIN_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CLAIM_WIN: claim_win_q <= cfg_data;
				CFG_DEDUP_WIN: dedup_win_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Latch the accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= in_item;
			kind_q <= kind_t'(s_tuser);
		end
	end

	// Scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.accept || cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.scan_claim || cmd.scan_hit) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Tag read data with its ring and the entry's valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_claim_s1  <= 1'b0;
			rd_hit_s1    <= 1'b0;
			vld_claim_s1 <= 1'b0;
			vld_hit_s1   <= 1'b0;
		end else begin
			rd_claim_s1  <= cmd.scan_claim;
			rd_hit_s1    <= cmd.scan_hit;
			vld_claim_s1 <= cmd.scan_claim && claim_valid_q[idx_q[CLAIM_AW-1:0]];
			vld_hit_s1   <= cmd.scan_hit && hit_valid_q[idx_q[HIT_AW-1:0]];
		end
	end

	assign claim_we  = cmd.finish && (kind_q == KIND_CLAIM);
	assign hit_we    = cmd.finish && (outcome == OUT_NEW_HIT);
	assign clear_all = cmd.finish && kind_q[1];

	wchm_ram #(.WIDTH(ENTRY_W), .DEPTH(CLAIM_DEPTH)) u_claim_ram (
		.clk   (clk),
		.we    (claim_we),
		.waddr (claim_ptr_q),
		.wdata (item_q),
		.raddr (idx_q[CLAIM_AW-1:0]),
		.rdata (claim_rd)
	);

	wchm_ram #(.WIDTH(ENTRY_W), .DEPTH(HIT_DEPTH)) u_hit_ram (
		.clk   (clk),
		.we    (hit_we),
		.waddr (hit_ptr_q),
		.wdata (item_q),
		.raddr (idx_q[HIT_AW-1:0]),
		.rdata (hit_rd)
	);

	// Compare the entry read last cycle against the held item
	assign claim_match = rd_claim_s1 && vld_claim_s1 && entry_hits(claim_rd, item_q, claim_win_q);
	assign hit_match   = rd_hit_s1 && vld_hit_s1 && entry_hits(hit_rd, item_q, dedup_win_q);

	// Accumulate match flags over the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			claimed_q <= 1'b0;
			dup_q     <= 1'b0;
		end else if (cmd.accept) begin
			claimed_q <= 1'b0;
			dup_q     <= 1'b0;
		end else begin
			claimed_q <= claimed_q | claim_match;
			dup_q     <= dup_q | hit_match;
		end
	end

	// Valid bits and write pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			claim_valid_q <= '0;
			hit_valid_q   <= '0;
			claim_ptr_q   <= '0;
			hit_ptr_q     <= '0;
		end else if (clear_all) begin
			claim_valid_q <= '0;
			hit_valid_q   <= '0;
			claim_ptr_q   <= '0;
			hit_ptr_q     <= '0;
		end else begin
			if (claim_we) begin
				claim_valid_q[claim_ptr_q] <= 1'b1;
				claim_ptr_q <= (claim_ptr_q == CLAIM_AW'(CLAIM_DEPTH - 1)) ? '0
					: claim_ptr_q + 1'b1;
			end
			if (hit_we) begin
				hit_valid_q[hit_ptr_q] <= 1'b1;
				hit_ptr_q <= (hit_ptr_q == HIT_AW'(HIT_DEPTH - 1)) ? '0
					: hit_ptr_q + 1'b1;
			end
		end
	end

	// Outcome of the held item
	always_comb begin
		case (kind_q) inside
			KIND_CLAIM: begin
				outcome = OUT_CLAIM_STORED;
			end
			KIND_OBSERVE: begin
				if (item_q.path == '0) begin
					outcome = OUT_EMPTY_PATH;
				end else if (claimed_q) begin
					outcome = OUT_CLAIMED;
				end else if (dup_q) begin
					outcome = OUT_DUPLICATE;
				end else begin
					outcome = OUT_NEW_HIT;
				end
			end
			KIND_CLEAR, KIND_CLEAR_ALT: begin
				outcome = OUT_CLEARED;
			end
			default: begin
				outcome = OUT_CLEARED;
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_outcome_q <= outcome;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - OUTC_W - 1){1'b0}}, out_outcome_q,
		out_outcome_q == OUT_NEW_HIT};

	assign sts.needs_scan = (kind_t'(s_tuser) == KIND_OBSERVE) && (in_item.path != '0);
	assign sts.last_claim = idx_q == SCAN_W'(CLAIM_DEPTH - 1);
	assign sts.last_hit   = idx_q == SCAN_W'(HIT_DEPTH - 1);
	assign sts.out_free   = !out_valid_q || m_tready;

	`WCHM_ASSERT_NOW(a_finish_free, clk, arst_n, cmd.finish, sts.out_free, "result overwritten")
	`WCHM_ASSERT_NEXT(a_finish_loads, clk, arst_n, cmd.finish, out_valid_q, "no result after finish")

endmodule
